/* sv/assert_macros.svh */
// Assertion macros used by the tokenizer RTL (csvlt_queue).
// Needs nothing else; files that assert include it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CSVLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CSVLT_NEVER(lbl, clk, rst_n, cond, msg) \
    `CSVLT_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

/* sv/csvlt_pkg.sv */
// Shared types and constants of the CSV line tokenizer.
// No dependencies; imported by every tokenizer module.
package csvlt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TERM  = 8'h00;

    localparam logic [7:0] DELIM_RESET = 8'd44;

    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_COLEND  = 3'd1,
        EV_RESTART = 3'd2,
        EV_LINEEND = 3'd3,
        EV_NLQUOTE = 3'd4,
        EV_UNTERM  = 3'd5
    } ev_kind_t;

    // One classified input byte: a first event, optionally followed by line end
    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] data;
        logic       two;
    } entry_t;

endpackage

/* sv/csvlt_front.sv */
// Front part of the tokenizer: accepts line bytes and runs the column parser.
// Depends on csvlt_pkg; feeds classified events into csvlt_queue.
module csvlt_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           delimiter,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,     // [7:0] line_byte
    input  logic                 q_full,
    output logic                 q_push,
    output csvlt_pkg::entry_t    q_entry
);
    import csvlt_pkg::*;

    typedef enum logic [2:0] {
        M_BETWEEN = 3'd0,
        M_COLUMN  = 3'd1,
        M_QUOTED  = 3'd2,
        M_QSEEN   = 3'd3,
        M_SKIP    = 3'd4,
        M_DROP    = 3'd5
    } mode_t;

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [7:0] prev_reg;
    logic       start_reg;

    logic       accept;
    logic       is_delim;
    logic       ended;
    logic       ev_valid;
    ev_kind_t   ev_kind;
    logic [7:0] ev_data;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_delim = (s_tdata == delimiter) && (s_tdata != CH_TERM);

    // Classify the byte against the current mode
    always_comb
    begin
        mode_next = mode_reg;
        ended     = 1'b0;
        ev_valid  = 1'b0;
        ev_kind   = EV_DATA;
        ev_data   = 8'd0;
        case (mode_reg)
            M_COLUMN:
            begin
                if (s_tdata == CH_TERM)
                begin
                    ev_valid = 1'b1;
                    ev_kind  = EV_COLEND;
                    ended    = 1'b1;
                end
                else if (is_delim || s_tdata == CH_NL)
                begin
                    ev_valid  = 1'b1;
                    ev_kind   = EV_COLEND;
                    mode_next = M_BETWEEN;
                end
                else if (s_tdata == CH_QUOTE)
                begin
                    ev_valid  = 1'b1;
                    ev_kind   = EV_RESTART;
                    mode_next = M_QUOTED;
                end
                else
                begin
                    ev_valid = 1'b1;
                    ev_data  = s_tdata;
                end
            end
            M_QUOTED:
            begin
                if (s_tdata == CH_QUOTE)
                begin
                    mode_next = M_QSEEN;
                end
                else if (s_tdata == CH_NL)
                begin
                    ev_valid  = 1'b1;
                    ev_kind   = EV_NLQUOTE;
                    mode_next = M_DROP;
                end
                else if (s_tdata == CH_TERM)
                begin
                    ev_valid = 1'b1;
                    ev_kind  = EV_UNTERM;
                    ended    = 1'b1;
                end
                else
                begin
                    ev_valid = 1'b1;
                    ev_data  = s_tdata;
                end
            end
            M_QSEEN:
            begin
                ev_valid = 1'b1;
                if (s_tdata == CH_QUOTE)
                begin
                    ev_data   = s_tdata;
                    mode_next = M_QUOTED;
                end
                else
                begin
                    ev_kind = EV_COLEND;
                    if (s_tdata == CH_TERM)
                        ended = 1'b1;
                    else if (is_delim || s_tdata == CH_NL)
                        mode_next = M_BETWEEN;
                    else
                        mode_next = M_SKIP;
                end
            end
            M_SKIP:
            begin
                if (s_tdata == CH_TERM)
                    ended = 1'b1;
                else if (is_delim || s_tdata == CH_NL)
                    mode_next = M_BETWEEN;
            end
            M_DROP:
            begin
                if (s_tdata == CH_TERM)
                    ended = 1'b1;
            end
            default:
            begin
                // between columns, and the unused codes
                if (s_tdata == CH_TERM)
                begin
                    ended = 1'b1;
                end
                else if (is_delim)
                begin
                    if (start_reg || prev_reg == delimiter)
                    begin
                        ev_valid = 1'b1;
                        ev_kind  = EV_COLEND;
                    end
                    mode_next = M_BETWEEN;
                end
                else if (s_tdata == CH_NL)
                begin
                    mode_next = M_BETWEEN;
                end
                else if (s_tdata == CH_QUOTE)
                begin
                    mode_next = M_QUOTED;
                end
                else
                begin
                    ev_valid  = 1'b1;
                    ev_data   = s_tdata;
                    mode_next = M_COLUMN;
                end
            end
        endcase
    end

    // Append line end to the first event, or send it alone
    always_comb
    begin
        q_entry.kind = ev_kind;
        q_entry.data = ev_data;
        q_entry.two  = 1'b0;
        if (ended)
        begin
            if (ev_valid)
                q_entry.two = 1'b1;
            else
                q_entry.kind = EV_LINEEND;
        end
    end

    assign q_push = accept && (ev_valid || ended);

    // Advance the parser state on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_BETWEEN;
            prev_reg  <= 8'd0;
            start_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (ended)
            begin
                mode_reg  <= M_BETWEEN;
                prev_reg  <= 8'd0;
                start_reg <= 1'b1;
            end
            else
            begin
                mode_reg  <= mode_next;
                prev_reg  <= s_tdata;
                start_reg <= 1'b0;
            end
        end
    end

endmodule

/* sv/csvlt_queue.sv */
// Short event queue between the parser front and the output back end.
// Depends on csvlt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csvlt_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  csvlt_pkg::entry_t    push_entry,
    input  logic                 pop,
    output csvlt_pkg::entry_t    head,
    output logic                 empty,
    output logic                 full
);
    import csvlt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Store entries at the write pointer
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    // Move pointers and track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `CSVLT_NEVER(a_no_overflow, clk, rst_n, push && full && !pop, "queue written while full")
    `CSVLT_NEVER(a_no_underflow, clk, rst_n, pop && empty, "queue read while empty")
    `CSVLT_ASSERT(a_count_up, clk, rst_n,
                  (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1),
                  "queue count did not rise")

endmodule

/* sv/csvlt_back.sv */
// Back end of the tokenizer: turns queued entries into output events.
// Depends on csvlt_pkg; reads from csvlt_queue.
module csvlt_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  csvlt_pkg::entry_t    head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,     // [7:0] column_byte
    output logic [2:0]           m_tuser,     // [2:0] event_kind
    output logic                 m_tlast
);
    import csvlt_pkg::*;

    logic       valid_reg;
    ev_kind_t   kind_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       second_reg;
    logic       load;

    assign load = !valid_reg || m_tready;
    // a two-event entry leaves the queue with its line end
    assign pop  = load && !empty && (!head.two || second_reg);

    // Load the output register from the queue head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            if (!empty && head.two && !second_reg)
                second_reg <= 1'b1;
            else if (!empty)
                second_reg <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            if (second_reg)
            begin
                kind_reg <= EV_LINEEND;
                data_reg <= 8'd0;
                last_reg <= 1'b1;
            end
            else
            begin
                kind_reg <= head.kind;
                data_reg <= head.data;
                last_reg <= !head.two;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

/* sv/csv_line_tokenizer_core.sv */
// CSV line tokenizer top level: APB register, parser front, queue, event back end.
// Depends on csvlt_pkg, csvlt_front, csvlt_queue and csvlt_back.
//
//   Channel  Dir  Handshake                 Payload
//   s_*      in   s_tvalid/s_tready         tdata = line_byte
//   m_*      out  m_tvalid/m_tready         tdata = column_byte, tuser = event_kind,
//                                           tlast = last
//   APB      in   psel/penable/pready       delimiter at address 0
//
// One byte is accepted per cycle while the queue has room; the parser decides its
// events in the cycle of acceptance, and they reach m_* through the queue memory and
// the output register, which sends one event per cycle while m_tready is high. A byte
// that causes two events (line end after another) keeps its entry at the queue head
// until both are sent. Reset is asynchronous, active low, and needs no clearing pass.
// A stalled m_tready fills the queue (QUEUE_DEPTH entries) and then drops s_tready.
module csv_line_tokenizer_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] line_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] column_byte
    output logic [2:0]  m_tuser,     // [2:0] event_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import csvlt_pkg::*;

    logic [7:0] delim_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    entry_t     q_entry;
    entry_t     q_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, delim_reg} : 32'd0;

    // Hold the delimiter register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delim_reg <= DELIM_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            delim_reg <= pwdata[7:0];
    end

    csvlt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .delimiter (delim_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    csvlt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    csvlt_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
